// ===== hw/rtl/bdpc_pkg.sv =====
`default_nettype none

package bdpc_pkg;

	localparam int BUTTON_COUNT = 6;
	localparam int TIMER_BITS = 16;
	localparam int CFG_TIME_BITS = 16;
	localparam int CMP_BITS = (TIMER_BITS > CFG_TIME_BITS) ? TIMER_BITS : CFG_TIME_BITS;

	localparam int KEY_BITS = 8;
	localparam int KIND_BITS = 2;
	localparam int BTN_BITS = 3;
	localparam int TABLE_KEYS = 6;
	localparam int TABLE_BITS = TABLE_KEYS * KEY_BITS;

	localparam int EVENT_KINDS = 3;
	localparam int EVENT_BITS = EVENT_KINDS * BUTTON_COUNT;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_BYTES_BITS = 8;
	localparam int OUT_DATA_BITS = 16;

	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_MS   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS_MS = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX_ENABLE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX_ONCE   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX_KEY    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_KEY      = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_TABLE     = 3'd6;

	localparam logic [KIND_BITS-1:0] KIND_PREFIX = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_SHORT  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_LONG   = 2'd2;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [EVENT_BITS-1:0] evmask_t;

	typedef struct packed {
		logic [CFG_TIME_BITS-1:0] debounce_ms;
		logic [CFG_TIME_BITS-1:0] long_press_ms;
		logic                     prefix_enable;
		logic                     prefix_once;
		logic [KEY_BITS-1:0]      prefix_key;
		logic [KEY_BITS-1:0]      long_key;
		logic [TABLE_BITS-1:0]    key_table;
	} cfg_t;

	function automatic timer_t sat_inc(input timer_t v);
		timer_t r;
		if (v == '1) begin
			r = v;
		end else begin
			r = v + timer_t'(1);
		end
		return r;
	endfunction

	function automatic logic [KEY_BITS-1:0] short_key(input logic [TABLE_BITS-1:0] tbl,
		input logic [BTN_BITS-1:0] idx);
		logic [KEY_BITS-1:0] r;
		r = '0;
		for (int k = 0; k < TABLE_KEYS; k++) begin
			if (idx == BTN_BITS'(k)) begin
				r = tbl[k*KEY_BITS +: KEY_BITS];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdpc_queue.sv =====
`default_nettype none

module bdpc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire bdpc_pkg::evmask_t push_data,
	input  wire                  pop,
	output logic                 full,
	output logic                 nonempty,
	output bdpc_pkg::evmask_t    head
);
	import bdpc_pkg::*;

	evmask_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
		logic [QPTR_BITS-1:0] r;
		if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_BITS'(1);
		end
		return r;
	endfunction

	assign full = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !nonempty)) else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_BITS'(1)))
		else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bdpc_front.sv =====
`default_nettype none

module bdpc_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire bdpc_pkg::cfg_t            cfg,
	input  wire                            tick_valid,
	input  wire [bdpc_pkg::BUTTON_COUNT-1:0] raw_levels,
	input  wire                            link_up,
	input  wire                            queue_full,
	output logic                           tick_ready,
	output logic                           push,
	output bdpc_pkg::evmask_t              push_data
);
	import bdpc_pkg::*;

	logic [BUTTON_COUNT-1:0] prev_q;
	logic [BUTTON_COUNT-1:0] deb_q;
	logic [BUTTON_COUNT-1:0] held_q;
	logic [BUTTON_COUNT-1:0] long_done_q;
	timer_t                  stable_q [BUTTON_COUNT];
	timer_t                  hold_q [BUTTON_COUNT];
	logic                    armed_q;

	logic [BUTTON_COUNT-1:0] deb_d;
	logic [BUTTON_COUNT-1:0] held_d;
	logic [BUTTON_COUNT-1:0] long_done_d;
	timer_t                  stable_d [BUTTON_COUNT];
	timer_t                  hold_d [BUTTON_COUNT];
	logic                    armed_d;
	evmask_t                 mask;
	logic                    take;

	always_comb begin
		logic   lvl;
		logic   dl;
		logic   held;
		logic   ld;
		logic   armed;
		timer_t st;
		timer_t ht;
		armed = armed_q;
		mask = '0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			lvl = raw_levels[i];
			dl = deb_q[i];
			held = held_q[i];
			ld = long_done_q[i];
			st = (lvl != prev_q[i]) ? '0 : sat_inc(stable_q[i]);
			ht = held_q[i] ? sat_inc(hold_q[i]) : hold_q[i];
			if ((CMP_BITS'(st) > CMP_BITS'(cfg.debounce_ms)) && (lvl != dl)) begin
				dl = lvl;
				if (!lvl) begin
					held = 1'b1;
					ht = '0;
					ld = 1'b0;
				end else if (held) begin
					if (!ld && (CMP_BITS'(ht) < CMP_BITS'(cfg.long_press_ms))) begin
						if (cfg.prefix_enable && (!cfg.prefix_once || armed)) begin
							mask[EVENT_KINDS*i + int'(KIND_PREFIX)] = link_up;
							if (cfg.prefix_once) begin
								armed = 1'b0;
							end
						end
						mask[EVENT_KINDS*i + int'(KIND_SHORT)] = link_up;
					end
					held = 1'b0;
					ld = 1'b0;
				end
			end
			if (held && !ld && (CMP_BITS'(ht) >= CMP_BITS'(cfg.long_press_ms))) begin
				mask[EVENT_KINDS*i + int'(KIND_LONG)] = link_up;
				armed = 1'b1;
				ld = 1'b1;
			end
			deb_d[i] = dl;
			held_d[i] = held;
			long_done_d[i] = ld;
			stable_d[i] = st;
			hold_d[i] = ht;
		end
		armed_d = armed;
	end

	assign tick_ready = !queue_full;
	assign take = tick_valid && !queue_full;
	assign push = take && (mask != '0);
	assign push_data = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
			deb_q <= '1;
			held_q <= '0;
			long_done_q <= '0;
			armed_q <= 1'b1;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				stable_q[i] <= '1;
				hold_q[i] <= '0;
			end
		end else if (take) begin
			prev_q <= raw_levels;
			deb_q <= deb_d;
			held_q <= held_d;
			long_done_q <= long_done_d;
			armed_q <= armed_d;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				stable_q[i] <= stable_d[i];
				hold_q[i] <= hold_d[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bdpc_back.sv =====
`default_nettype none

module bdpc_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire bdpc_pkg::cfg_t                cfg,
	input  wire                                queue_nonempty,
	input  wire bdpc_pkg::evmask_t             queue_head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [bdpc_pkg::KEY_BITS-1:0]      key_code,
	output logic [bdpc_pkg::KIND_BITS-1:0]     event_kind,
	output logic [bdpc_pkg::BTN_BITS-1:0]      button_index,
	output logic                               last_of_tick
);
	import bdpc_pkg::*;

	evmask_t               cur_q;
	logic                  out_valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KIND_BITS-1:0]  kind_q;
	logic [BTN_BITS-1:0]   btn_q;
	logic                  last_q;

	evmask_t               low;
	evmask_t               rest;
	logic                  have;
	logic                  adv;
	logic [KIND_BITS-1:0]  sel_kind;
	logic [BTN_BITS-1:0]   sel_btn;
	logic [KEY_BITS-1:0]   sel_key;

	assign have = (cur_q != '0);
	assign adv = !out_valid_q || out_ready;
	assign low = cur_q & (~cur_q + evmask_t'(1));
	assign rest = cur_q & ~low;
	assign pop = queue_nonempty && (!have || (adv && (rest == '0)));

	always_comb begin
		sel_kind = KIND_PREFIX;
		sel_btn = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			for (int k = 0; k < EVENT_KINDS; k++) begin
				if (low[EVENT_KINDS*b + k]) begin
					sel_kind = KIND_BITS'(k);
					sel_btn = BTN_BITS'(b);
				end
			end
		end
		case (sel_kind)
			KIND_PREFIX: sel_key = cfg.prefix_key;
			KIND_SHORT:  sel_key = short_key(cfg.key_table, sel_btn);
			KIND_LONG:   sel_key = cfg.long_key;
			default:     sel_key = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			key_q <= sel_key;
			kind_q <= sel_kind;
			btn_q <= sel_btn;
			last_q <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= have;
			end
			if (pop) begin
				cur_q <= queue_head;
			end else if (adv && have) begin
				cur_q <= rest;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign key_code = key_q;
	assign event_kind = kind_q;
	assign button_index = btn_q;
	assign last_of_tick = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_press_classifier_top.sv =====
`default_nettype none

// Debounces six active-low buttons and turns presses into key codes. Every input
// transfer is one millisecond tick; a press held past the long-press time yields the
// long key once, a shorter press yields an optional prefix key and then the button's
// own key, buttons in index order, with the event kind on tuser and tlast on the final
// key of a tick. A new tick may be taken every cycle while the four-entry tick queue has
// room; key results leave at one per cycle while m_tready is high, and a tick can carry
// up to twelve keys. Ticks that produce no key, including all ticks with the link down,
// never enter the queue. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while idle, as the block does not enforce this.
module button_debounce_press_classifier_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_index,
	input  wire [47:0]  cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [7:0]   s_tdata,   // raw_levels[5:0], link_up[6], zero[7]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // key_code[7:0], button_index[10:8], zero[15:11]
	output logic [1:0]  m_tuser,   // event_kind[1:0]
	output logic        m_tlast
);
	import bdpc_pkg::*;

	cfg_t                  cfg_q;
	logic                  q_full;
	logic                  q_nonempty;
	logic                  q_push;
	logic                  q_pop;
	evmask_t               q_in;
	evmask_t               q_head;
	logic [KEY_BITS-1:0]   key_code;
	logic [KIND_BITS-1:0]  event_kind;
	logic [BTN_BITS-1:0]   button_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= CFG_TIME_BITS'(30);
			cfg_q.long_press_ms <= CFG_TIME_BITS'(800);
			cfg_q.prefix_enable <= 1'b0;
			cfg_q.prefix_once <= 1'b0;
			cfg_q.prefix_key <= '0;
			cfg_q.long_key <= '0;
			cfg_q.key_table <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_MS:   cfg_q.debounce_ms <= cfg_data[CFG_TIME_BITS-1:0];
				REG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_data[CFG_TIME_BITS-1:0];
				REG_PREFIX_ENABLE: cfg_q.prefix_enable <= cfg_data[0];
				REG_PREFIX_ONCE:   cfg_q.prefix_once <= cfg_data[0];
				REG_PREFIX_KEY:    cfg_q.prefix_key <= cfg_data[KEY_BITS-1:0];
				REG_LONG_KEY:      cfg_q.long_key <= cfg_data[KEY_BITS-1:0];
				REG_KEY_TABLE:     cfg_q.key_table <= cfg_data[TABLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	bdpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick_valid (s_tvalid),
		.raw_levels (s_tdata[BUTTON_COUNT-1:0]),
		.link_up    (s_tdata[BUTTON_COUNT]),
		.queue_full (q_full),
		.tick_ready (s_tready),
		.push       (q_push),
		.push_data  (q_in)
	);

	bdpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	bdpc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.queue_nonempty (q_nonempty),
		.queue_head     (q_head),
		.pop            (q_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.key_code       (key_code),
		.event_kind     (event_kind),
		.button_index   (button_index),
		.last_of_tick   (m_tlast)
	);

	assign m_tdata = {5'b00000, button_index, key_code};
	assign m_tuser = event_kind;

endmodule

`default_nettype wire
